// File: rtl/core/cam_pkg.sv
// Shared types and constants for the cartridge address mapper.
// No dependencies; cam_decode, cartridge_address_mapper and cam_checker refer to this package.
package cam_pkg;

  localparam int unsigned DefSramAddrBits   = 15;
  localparam int unsigned DefRomAddrBitsMax = 23;

  localparam int unsigned RomAddrW  = 23;
  localparam int unsigned CopAddrW  = 16;
  localparam int unsigned RawRamW   = 19;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 5;

  localparam logic [CfgIdxW-1:0] RegMappingMode = 2'd0;
  localparam logic [CfgIdxW-1:0] RegRomAddrBits = 2'd1;
  localparam logic [CfgIdxW-1:0] RegRamAddrBits = 2'd2;

  localparam logic [2:0] ModeNone    = 3'd0;
  localparam logic [2:0] ModeLoRom   = 3'd1;
  localparam logic [2:0] ModeHiRom   = 3'd2;
  localparam logic [2:0] ModeExHiRom = 3'd3;
  localparam logic [2:0] ModeLoRomCp = 3'd4;

  localparam logic [4:0] RomAddrBitsRst = 5'd23;

  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_ROM  = 2'd1,
    TGT_RAM  = 2'd2,
    TGT_COP  = 2'd3
  } target_e;

  typedef struct packed {
    logic [2:0] mode;
    logic [4:0] rom_bits;
    logic [3:0] ram_bits;
  } cfg_t;

  typedef struct packed {
    target_e               target;
    logic [RomAddrW-1:0]   rom_addr;
    logic [CopAddrW-1:0]   cop_addr;
    logic                  ram_hit;
    logic                  ram_wr;
  } dec_t;

endpackage

// File: rtl/core/cam_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module cam_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem_q[addr_i];
      end
    end
  end

endmodule

// File: rtl/core/cam_decode.sv
// Address decode of one bus access by mapping mode: target, ROM address,
// coprocessor address and save RAM index. Depends on cam_pkg.
module cam_decode #(
  parameter int unsigned SRAM_ADDR_BITS    = cam_pkg::DefSramAddrBits,
  parameter int unsigned ROM_ADDR_BITS_MAX = cam_pkg::DefRomAddrBitsMax
) (
  input  cam_pkg::cfg_t              cfg_i,
  input  logic                       wr_i,
  input  logic [7:0]                 bank_i,
  input  logic [15:0]                addr_i,
  output cam_pkg::dec_t              dec_o,
  output logic [SRAM_ADDR_BITS-1:0]  ram_idx_o
);

  localparam logic [4:0] RomBitsMax = 5'(ROM_ADDR_BITS_MAX);

  logic                         lo_bank;
  logic                         win;
  logic                         has_ram;
  logic [4:0]                   rom_bits;
  logic [cam_pkg::RomAddrW:0]   rom_mask_full;
  logic [cam_pkg::RomAddrW-1:0] rom_mask;
  logic [cam_pkg::RawRamW-1:0]  ram_mask;
  logic [cam_pkg::RawRamW-1:0]  raw_idx;
  logic [cam_pkg::RomAddrW-1:0] rom_raw;
  logic                         lo_ram_bank;

  always_comb begin
    lo_bank       = ~bank_i[6];
    win           = (addr_i[15:13] == 3'b011);
    has_ram       = (cfg_i.ram_bits != 4'd0);
    rom_bits      = (cfg_i.rom_bits > RomBitsMax) ? RomBitsMax : cfg_i.rom_bits;
    rom_mask_full = ((cam_pkg::RomAddrW+1)'(1) << rom_bits) - (cam_pkg::RomAddrW+1)'(1);
    rom_mask      = rom_mask_full[cam_pkg::RomAddrW-1:0];
    ram_mask      = (cam_pkg::RawRamW'(1) << cfg_i.ram_bits) - cam_pkg::RawRamW'(1);
    lo_ram_bank   = ((bank_i >= 8'h70) && (bank_i < 8'h7E)) || (bank_i >= 8'hF0);

    dec_o          = '0;
    dec_o.target   = cam_pkg::TGT_NONE;
    dec_o.ram_wr   = wr_i;
    raw_idx        = '0;
    rom_raw        = '0;

    case (cfg_i.mode)
      cam_pkg::ModeLoRom, cam_pkg::ModeLoRomCp: begin
        if ((cfg_i.mode == cam_pkg::ModeLoRomCp) && lo_bank && win) begin
          dec_o.target   = cam_pkg::TGT_COP;
          dec_o.cop_addr = addr_i;
        end else if (lo_ram_bank && !addr_i[15] && has_ram) begin
          dec_o.ram_hit = 1'b1;
          dec_o.target  = cam_pkg::TGT_RAM;
          raw_idx       = {bank_i[3:0], addr_i[14:0]};
        end else if (addr_i[15] || bank_i[6]) begin
          if (!wr_i) begin
            rom_raw        = {1'b0, bank_i[6:0], addr_i[14:0]};
            dec_o.target   = cam_pkg::TGT_ROM;
            dec_o.rom_addr = rom_raw & rom_mask;
          end
        end
      end
      cam_pkg::ModeHiRom, cam_pkg::ModeExHiRom: begin
        if (lo_bank && win && has_ram) begin
          dec_o.ram_hit = 1'b1;
          dec_o.target  = cam_pkg::TGT_RAM;
          raw_idx       = {bank_i[5:0], addr_i[12:0]};
        end else if (addr_i[15] || !lo_bank) begin
          if (!wr_i) begin
            rom_raw        = {(cfg_i.mode == cam_pkg::ModeExHiRom) && !bank_i[7],
                              bank_i[5:0], addr_i};
            dec_o.target   = cam_pkg::TGT_ROM;
            dec_o.rom_addr = rom_raw & rom_mask;
          end
        end
      end
      default: begin
        dec_o.target = cam_pkg::TGT_NONE;
      end
    endcase
  end

  assign ram_idx_o = SRAM_ADDR_BITS'(raw_idx & ram_mask);

endmodule

// File: rtl/core/cartridge_address_mapper.sv
// Top level of the cartridge address mapper: configuration registers, decode
// stage, save RAM with its clearing pass, output register.
// Depends on cam_pkg, cam_decode and cam_ram.
//
//   Channel   Direction  Beat contents (lowest bits first)
//   s_axis    in         tuser: operation; tdata: bank, address, write_data
//   m_axis    out        tuser: target; tdata: rom_address, read_data, coproc_address
//   cfg       in         cfg_addr_i: register index; cfg_wdata_i: value
//
// One beat is taken per cycle while s_axis_tready is high; a beat is registered
// in the decode stage, beside the save RAM's registered read port, then in the
// output register. After reset the save RAM is cleared one byte per cycle, all
// 2**SRAM_ADDR_BITS bytes (32768 by default); s_axis_tready stays low until that
// pass ends. A stalled output holds its beat and backs the pipeline up into s_axis.
module cartridge_address_mapper #(
  parameter int unsigned SRAM_ADDR_BITS    = cam_pkg::DefSramAddrBits,
  parameter int unsigned ROM_ADDR_BITS_MAX = cam_pkg::DefRomAddrBitsMax
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [31:0]                  s_axis_tdata,  // bank, address, write_data
  input  logic                         s_axis_tuser,  // operation
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [47:0]                  m_axis_tdata,  // rom_address, read_data, coproc_address
  output logic [1:0]                   m_axis_tuser,  // target
  input  logic                         cfg_we_i,
  input  logic [cam_pkg::CfgIdxW-1:0]  cfg_addr_i,
  input  logic [cam_pkg::CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned SramDepth = 1 << SRAM_ADDR_BITS;

  cam_pkg::cfg_t             cfg_q;
  cam_pkg::dec_t             dec;
  cam_pkg::dec_t             st_q;
  logic                      st_valid_q;
  logic [SRAM_ADDR_BITS-1:0] ram_idx;
  logic [SRAM_ADDR_BITS-1:0] clr_q;
  logic                      clr_busy_q;
  logic                      accept;
  logic                      advance;
  logic                      ram_en;
  logic                      ram_we;
  logic [SRAM_ADDR_BITS-1:0] ram_addr;
  logic [7:0]                ram_wdata;
  logic [7:0]                ram_rdata;
  logic [7:0]                rd_data;
  logic                      out_valid_q;
  logic [47:0]               out_data_q;
  logic [1:0]                out_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode     <= cam_pkg::ModeNone;
      cfg_q.rom_bits <= cam_pkg::RomAddrBitsRst;
      cfg_q.ram_bits <= 4'd0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        cam_pkg::RegMappingMode: cfg_q.mode     <= cfg_wdata_i[2:0];
        cam_pkg::RegRomAddrBits: cfg_q.rom_bits <= cfg_wdata_i[4:0];
        cam_pkg::RegRamAddrBits: cfg_q.ram_bits <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  cam_decode #(
    .SRAM_ADDR_BITS   (SRAM_ADDR_BITS),
    .ROM_ADDR_BITS_MAX(ROM_ADDR_BITS_MAX)
  ) u_decode (
    .cfg_i    (cfg_q),
    .wr_i     (s_axis_tuser),
    .bank_i   (s_axis_tdata[7:0]),
    .addr_i   (s_axis_tdata[23:8]),
    .dec_o    (dec),
    .ram_idx_o(ram_idx)
  );

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !clr_busy_q && (!st_valid_q || advance);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      clr_q <= clr_q + SRAM_ADDR_BITS'(1);
      if (&clr_q) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_comb begin
    if (clr_busy_q) begin
      ram_en    = 1'b1;
      ram_we    = 1'b1;
      ram_addr  = clr_q;
      ram_wdata = 8'h00;
    end else begin
      ram_en    = accept && dec.ram_hit;
      ram_we    = dec.ram_wr;
      ram_addr  = ram_idx;
      ram_wdata = s_axis_tdata[31:24];
    end
  end

  cam_ram #(
    .WIDTH(8),
    .DEPTH(SramDepth)
  ) u_save_ram (
    .clk_i  (clk_i),
    .en_i   (ram_en),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= 1'b0;
    end else if (accept) begin
      st_valid_q <= 1'b1;
    end else if (advance) begin
      st_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_q <= dec;
    end
  end

  assign rd_data = (st_q.ram_hit && !st_q.ram_wr) ? ram_rdata : 8'h00;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= st_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && st_valid_q) begin
      out_data_q <= {1'b0, st_q.cop_addr, rd_data, st_q.rom_addr};
      out_user_q <= st_q.target;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

// File: rtl/core/cam_checker.sv
// Port-level assertions on the cartridge address mapper and the bind that
// attaches them to the top level. Depends on cam_pkg.
module cam_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

  a_rom_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != cam_pkg::TGT_ROM) |-> m_axis_tdata[22:0] == 23'd0)
    else $error("ROM address set on a non-ROM result");

  a_rd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != cam_pkg::TGT_RAM) |-> m_axis_tdata[30:23] == 8'd0)
    else $error("read data set on a non-RAM result");

  a_cop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != cam_pkg::TGT_COP) |-> m_axis_tdata[46:31] == 16'd0)
    else $error("coprocessor address set on a non-coprocessor result");

endmodule

bind cartridge_address_mapper cam_checker u_cam_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
